@@ rtl/core/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Bitmap geometry. The store holds STORE_WORDS words; only the first
  // WORDS_USED of them hold blocks.
  localparam int MAP_WORDS   = 16;
  localparam int STORE_WORDS = 16;
  localparam int WORDS_USED  = (MAP_WORDS > STORE_WORDS) ? STORE_WORDS :
                               ((MAP_WORDS < 1) ? 1 : MAP_WORDS);
  localparam int WORD_BITS   = 64;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int BLOCKS_USED = WORDS_USED * WORD_BITS;

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming request
    logic lookup;  // pick the word and start the memory read
    logic commit;  // modify, write back and present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // the result register can take a new word
  } dp_stat_t;

  // Value of a bitmap word before it is ever written.
  function automatic logic [WORD_BITS-1:0] init_word(input logic [ADDR_W-1:0] addr);
    logic [WORD_BITS-1:0] w;
    w = (int'(addr) < WORDS_USED) ? '1 : '0;
    return w;
  endfunction

  // Index of the lowest word whose nonzero flag is set.
  function automatic logic [ADDR_W-1:0] first_set(input logic [STORE_WORDS-1:0] flags);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = STORE_WORDS - 1; i >= 0; i--) begin
      if (flags[i]) begin
        r = ADDR_W'(i);
      end
    end
    return r;
  endfunction

  // Position of the highest set bit, counted from the MSB.
  function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        r = BIT_W'(WORD_BITS - 1 - i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::cmd_t     cmd
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state;

  // Sequence: take a word, pick and read the bitmap word, then commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (stat.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.lookup = (state == S_LOOKUP);
  assign cmd.commit = (state == S_UPDATE) && stat.slot_free;

endmodule

`default_nettype wire

@@ rtl/core/bba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bba_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  bba_pkg::cmd_t                  cmd,
  output bba_pkg::dp_stat_t              stat,
  input  logic                           operation,
  input  logic [bba_pkg::INDEX_W-1:0]    free_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [bba_pkg::INDEX_W-1:0]    block_index,
  output logic [bba_pkg::COUNT_W-1:0]    free_count
);
  import bba_pkg::*;

  // Request and lookup registers.
  logic                  op_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  any_q;

  // Per-word state: nonzero summary flags and written marks.
  logic [STORE_WORDS-1:0] nonzero;
  logic [STORE_WORDS-1:0] written;
  logic [COUNT_W-1:0]     count;

  logic [ADDR_W-1:0]    look_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] free_mask;
  logic [BIT_W-1:0]     alloc_pos;
  logic                 do_write;
  logic [COUNT_W-1:0]   count_next;
  status_t              st_next;
  logic [INDEX_W-1:0]   block_next;
  logic                 out_of_range;

  assign stat.slot_free = !out_valid || out_ready;

  // Word to read: the addressed word for a free, the first nonzero for an allocate.
  assign look_addr = (op_q == OP_FREE) ? idx_q[INDEX_W-1:BIT_W] : first_set(nonzero);

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(STORE_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (cmd.commit && do_write),
    .waddr(addr_q),
    .wdata(new_word),
    .re   (cmd.lookup),
    .raddr(look_addr),
    .rdata(rd_data)
  );

  // A word never written still holds its reset pattern.
  assign cur_word     = written[addr_q] ? rd_data : init_word(addr_q);
  assign alloc_pos    = msb_pos(cur_word);
  assign free_mask    = {1'b1, {(WORD_BITS-1){1'b0}}} >> idx_q[BIT_W-1:0];
  assign out_of_range = ({1'b0, idx_q} >= COUNT_W'(BLOCKS_USED));

  // Modify step and result for the pending request.
  always_comb begin
    new_word   = cur_word;
    do_write   = 1'b0;
    count_next = count;
    st_next    = ST_OK;
    block_next = '0;
    if (op_q == OP_ALLOC) begin
      if (!any_q) begin
        st_next = ST_NO_SPACE;
      end else begin
        new_word   = cur_word & ~({1'b1, {(WORD_BITS-1){1'b0}}} >> alloc_pos);
        do_write   = 1'b1;
        count_next = count - COUNT_W'(1);
        block_next = {addr_q, alloc_pos};
      end
    end else begin
      if (out_of_range) begin
        st_next = ST_OUT_OF_RANGE;
      end else if ((cur_word & free_mask) != '0) begin
        st_next = ST_ALREADY_FREE;
      end else begin
        new_word   = cur_word | free_mask;
        do_write   = 1'b1;
        count_next = count + COUNT_W'(1);
      end
    end
  end

  // Request capture and word selection.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      idx_q <= free_index;
    end
    if (cmd.lookup) begin
      addr_q <= look_addr;
      any_q  <= |nonzero[WORDS_USED-1:0];
    end
  end

  // Bitmap bookkeeping and free count.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      count   <= COUNT_W'(BLOCKS_USED);
      for (int i = 0; i < STORE_WORDS; i++) begin
        nonzero[i] <= (i < WORDS_USED);
      end
    end else if (cmd.commit && do_write) begin
      written[addr_q] <= 1'b1;
      nonzero[addr_q] <= |new_word;
      count           <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= st_next;
      block_index <= block_next;
      free_count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/block_bitmap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Word fields
// -------  -------------------  -------------------------------------
// in       in_valid / in_ready  operation, free_index
// out      out_valid/ out_ready status, block_index, free_count
//
// Each request goes through accept, word lookup with the memory read,
// and the modify and write-back of that bitmap word through one RAM port.
// The first nonzero word is picked combinationally from per-word summary flags.
// Reset is synchronous; it marks every block free at once, with no sweep.
// A result waits in the output register; the next request is accepted
// meanwhile and stalls only in its update state until the register frees up.
module block_bitmap_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [bba_pkg::INDEX_W-1:0] free_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [bba_pkg::INDEX_W-1:0] block_index,
  output logic [bba_pkg::COUNT_W-1:0] free_count
);
  import bba_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .free_index (free_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .block_index(block_index),
    .free_count (free_count)
  );

  // A new result appears only after a commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  // A request cannot commit in the cycle right after it is accepted.
  a_no_early_commit: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !cmd.commit)
    else $error("commit too early after accept");

  // No space is reported only when the count is zero, with no block.
  a_no_space_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_SPACE |-> free_count == '0 && block_index == '0)
    else $error("no space reported with free blocks left");

  // The free count never exceeds the number of blocks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_count <= COUNT_W'(BLOCKS_USED))
    else $error("free count out of bounds");

endmodule

`default_nettype wire

@@ test/tb_block_bitmap_allocator.sv @@
`timescale 1ns / 1ps

module tb_block_bitmap_allocator;
  import bba_pkg::*;

  // Expected answer to one request.
  typedef struct {
    logic               is_alloc;
    status_t            st;
    logic [INDEX_W-1:0] blk;
    logic [COUNT_W-1:0] cnt;
  } alloc_answer_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = OP_ALLOC;
  logic [INDEX_W-1:0] free_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [INDEX_W-1:0] block_index;
  logic [COUNT_W-1:0] free_count;

  block_bitmap_allocator u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .free_index (free_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .block_index(block_index),
    .free_count (free_count)
  );

  // Shadow copy of the free map and the free counter.
  logic [WORD_BITS-1:0] shadow_map [STORE_WORDS];
  logic [COUNT_W-1:0]   shadow_free;

  alloc_answer_t pending_answers [$];

  int  mismatch_count = 0;
  int  words_sent     = 0;
  int  seen_alloc_ok  = 0;
  int  seen_no_space  = 0;
  int  seen_free_ok   = 0;
  int  seen_dup_free  = 0;
  int  seen_range     = 0;
  bit  tx_idle_on     = 1'b0;
  bit  rx_idle_on     = 1'b0;
  int  rx_hold_left   = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    #3ms;
    $display("Timeout with %0d answers still pending.", pending_answers.size());
    $display("** block_bitmap_allocator: FAILED **");
    $finish;
  end

  // Apply one request to the shadow map and return what the block should answer.
  function automatic alloc_answer_t apply_request(input logic op,
                                                  input logic [INDEX_W-1:0] idx);
    alloc_answer_t r;
    int            w;
    int            pos;
    bit            found;
    r.is_alloc = (op == OP_ALLOC);
    r.st  = ST_OK;
    r.blk = '0;
    found = 1'b0;
    w     = 0;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < WORDS_USED; i++) begin
        if (!found && shadow_map[i] != '0) begin
          found = 1'b1;
          w     = i;
        end
      end
      if (!found) begin
        r.st = ST_NO_SPACE;
      end else begin
        // Highest set bit, numbered from the MSB as block offset zero.
        pos = WORD_BITS - 1;
        while (!shadow_map[w][pos]) pos--;
        shadow_map[w][pos] = 1'b0;
        shadow_free = shadow_free - COUNT_W'(1);
        r.blk = INDEX_W'(w * WORD_BITS + (WORD_BITS - 1 - pos));
      end
    end else begin
      if (int'(idx) >= BLOCKS_USED) begin
        r.st = ST_OUT_OF_RANGE;
      end else begin
        w   = int'(idx) / WORD_BITS;
        pos = WORD_BITS - 1 - (int'(idx) % WORD_BITS);
        if (shadow_map[w][pos]) begin
          r.st = ST_ALREADY_FREE;
        end else begin
          shadow_map[w][pos] = 1'b1;
          shadow_free = shadow_free + COUNT_W'(1);
        end
      end
    end
    r.cnt = shadow_free;
    return r;
  endfunction

  // Random block that the shadow map shows as taken, or a random one if none is.
  function automatic logic [INDEX_W-1:0] pick_used_block();
    int start;
    int b;
    start = $urandom_range(BLOCKS_USED - 1);
    for (int k = 0; k < BLOCKS_USED; k++) begin
      b = (start + k) % BLOCKS_USED;
      if (!shadow_map[b / WORD_BITS][WORD_BITS - 1 - (b % WORD_BITS)]) return INDEX_W'(b);
    end
    return INDEX_W'(start);
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // Offer one request word and record its expected answer once it is taken.
  // Called right after a falling edge; returns right after a falling edge.
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx);
    while (tx_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    free_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_request(op, idx));
    words_sent++;
    @(negedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_idle_on && $urandom_range(99) < 36) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every answer word with the oldest expectation.
  always @(posedge clk) begin
    alloc_answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with nothing pending, status", -1, status);
      end else begin
        e = pending_answers.pop_front();
        if (status != e.st) report_mismatch("status", e.st, status);
        if (block_index != e.blk) report_mismatch("block_index", e.blk, block_index);
        if (free_count != e.cnt) report_mismatch("free_count", e.cnt, free_count);
        case (e.st)
          ST_OK: begin
            if (e.is_alloc) begin
              seen_alloc_ok++;
            end else begin
              seen_free_ok++;
            end
          end
          ST_NO_SPACE:     seen_no_space++;
          ST_ALREADY_FREE: seen_dup_free++;
          default:         seen_range++;
        endcase
      end
    end
  end

  // Extremes of the index, the ignored index on allocate, and the ok and already-free statuses.
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_request(OP_FREE, '1);                // already free at reset, count full
    send_request(OP_ALLOC, '0);               // block 0
    send_request(OP_ALLOC, '1);               // index is ignored on allocate
    send_request(OP_FREE, '0);                // release block 0
    send_request(OP_FREE, '0);                // second release is a double free
    send_request(OP_ALLOC, 10'h155);          // block 0 comes back first
    send_request(OP_FREE, 10'h001);
    send_request(OP_FREE, 10'h2aa);           // never taken
    send_request(OP_FREE, 10'h155);
    send_request(OP_FREE, 10'd512);
    for (int i = 0; i < 6; i++) send_request(OP_ALLOC, INDEX_W'($urandom));
    send_request(OP_FREE, 10'd3);
    send_request(OP_FREE, 10'd5);
    send_request(OP_ALLOC, '0);               // lowest free bit is block 3 again
    send_request(OP_FREE, 10'd63);            // last bit of the first word
    send_request(OP_FREE, 10'd64);            // first bit of the second word
    // The last block of the map in use, which is always in range.
    send_request(OP_FREE, INDEX_W'(BLOCKS_USED - 1));
    send_request(OP_FREE, '1);
  endtask

  // Mostly allocations until the map is empty, then allocations into no space.
  task automatic test_fill_to_empty();
    for (int i = 0; i < 1080; i++) begin
      tx_idle_on = (i >= 300);
      rx_idle_on = (i >= 300);
      if ($urandom_range(99) < 96) begin
        send_request(OP_ALLOC, INDEX_W'($urandom));
      end else begin
        send_request(OP_FREE, INDEX_W'($urandom_range(1023)));
      end
    end
    while (shadow_free != '0) send_request(OP_ALLOC, INDEX_W'($urandom));
    for (int i = 0; i < 3; i++) send_request(OP_ALLOC, INDEX_W'($urandom));
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_hold_left = 80;
    for (int i = 0; i < 10; i++) send_request(OP_FREE, pick_used_block());
    rx_idle_on = 1'b1;
  endtask

  // Churn: mostly frees of taken blocks, mixed with allocations and stray frees.
  task automatic test_mixed_churn();
    int pick;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 150; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_request(OP_FREE, pick_used_block());
      end else if (pick < 90) begin
        send_request(OP_ALLOC, INDEX_W'($urandom));
      end else begin
        send_request(OP_FREE, INDEX_W'($urandom_range(1023)));
      end
    end
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < STORE_WORDS; i++) shadow_map[i] = (i < WORDS_USED) ? '1 : '0;
    shadow_free = COUNT_W'(BLOCKS_USED);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_fill_to_empty();
    test_backpressure();
    test_mixed_churn();

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d request words; map driven from all free to empty and back.",
             words_sent);
    $display("Answers: %0d alloc ok, %0d free ok, %0d no space, %0d double free, %0d out of range.",
             seen_alloc_ok, seen_free_ok, seen_no_space, seen_dup_free, seen_range);
    if (mismatch_count == 0) begin
      $display("** block_bitmap_allocator: PASSED **");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("** block_bitmap_allocator: FAILED **");
    end
    $finish;
  end

endmodule
